FILE: design/tdclp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdclp_pkg
// Shared types and constants for the text drive command line parser.
// ----------------------------------------------------------------------------
package tdclp_pkg;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_B     = 8'h42;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] CHAR_F     = 8'h46;
    localparam logic [7:0] CHAR_L     = 8'h4C;
    localparam logic [7:0] CHAR_O     = 8'h4F;
    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_S     = 8'h53;

    // magnitude ceiling: 2^31 keeps the most negative value reachable
    localparam logic [31:0] MAG_CAP   = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    localparam logic [15:0] FULL_SPEED_RST = 16'd200;
    localparam logic [15:0] TURN_SPEED_RST = 16'd180;

    localparam int RESULT_W = 67;
    localparam int TDATA_W  = 72;

    // register indexes on the config port (paddr[2])
    localparam logic REG_FULL_SPEED = 1'b0;
    localparam logic REG_TURN_SPEED = 1'b1;

    typedef struct packed {
        logic        loc_has_number;
        logic        loc_request;
        logic [31:0] steer;
        logic [31:0] forward;
        logic        drive_valid;
    } result_t;

endpackage

FILE: design/text_drive_command_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_drive_command_line_parser
// Gathers received bytes into a line and decodes drive and location commands.
// ----------------------------------------------------------------------------
//  channel   | dir | beat contents
//  s_axis    | in  | tdata[7:0] rx_byte
//  m_axis    | out | tdata: drive_valid, forward, steer, loc_request, loc_has_number
//  apb       | in  | 0x0 full_speed, 0x4 turn_speed (16 bit each)
//
//  One byte per cycle while the skid entry is empty; line state updates
//  in the accept cycle. A CR/LF with stored bytes loads its result into
//  the output register, or the skid entry if that holds a stalled beat.
//  Output register plus one skid entry: input stalls only while both hold
//  beats. No reset sweep; rst_n clears the line state at once.
// ----------------------------------------------------------------------------
module text_drive_command_line_parser #(
    parameter int LINE_CAP = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // bytes in
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    // results out
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] drive_valid, [32:1] forward, [64:33] steer, [65] loc_request,
    // [66] loc_has_number, [71:67] zero
    output logic [tdclp_pkg::TDATA_W-1:0] m_tdata,
    // config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int LW = $clog2(LINE_CAP);
    localparam logic [LW-1:0] LEN_MAX = LW'(LINE_CAP - 1);

    typedef enum logic [2:0] {
        PH_WS1, PH_SIGN1, PH_DIG1, PH_WS2, PH_SIGN2, PH_DIG2, PH_FAIL, PH_DONE
    } phase_t;

    // config registers
    logic [15:0] full_speed_reg;
    logic [15:0] turn_speed_reg;
    logic        cfg_wr;

    // line state
    logic [LW-1:0] line_len_reg, line_len_next;
    logic [2:0]    text_len_reg, text_len_next;   // saturates at 5
    logic [7:0]    head_reg [4];
    logic [7:0]    head_next [4];
    logic          zero_seen_reg, zero_seen_next;
    phase_t        phase_reg, phase_next;
    logic [31:0]   first_reg, first_next;
    logic [31:0]   second_reg, second_next;
    logic [1:0]    neg_reg, neg_next;

    // output stage
    logic                      out_valid_reg;
    tdclp_pkg::result_t        out_reg;
    logic                      skid_valid_reg;
    tdclp_pkg::result_t        skid_reg;
    tdclp_pkg::result_t        res;

    logic        in_acc, pop, push, is_eol, store, is_text;
    logic [7:0]  c;
    logic        c_ws, c_digit, c_sign, is_d_line;
    logic [31:0] acc_base, acc_val;
    logic [34:0] acc_wide;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (paddr[2] == tdclp_pkg::REG_TURN_SPEED) ? {16'd0, turn_speed_reg}
                                                             : {16'd0, full_speed_reg};

    assign c        = s_tdata;
    assign s_tready = !skid_valid_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign is_eol   = (c == tdclp_pkg::CHAR_LF) || (c == tdclp_pkg::CHAR_CR);
    assign push     = in_acc && is_eol && (line_len_reg != '0);
    assign store    = in_acc && !is_eol && (line_len_reg < LEN_MAX);
    assign is_text  = store && !zero_seen_reg && (c != 8'd0);

    assign c_ws    = (c == tdclp_pkg::CHAR_SPACE) ||
                     ((c >= tdclp_pkg::CHAR_TAB) && (c <= tdclp_pkg::CHAR_CR));
    assign c_digit = (c >= tdclp_pkg::CHAR_0) && (c <= tdclp_pkg::CHAR_9);
    assign c_sign  = (c == tdclp_pkg::CHAR_PLUS) || (c == tdclp_pkg::CHAR_MINUS);

    assign is_d_line = (text_len_reg >= 3'd2) && (head_reg[0] == tdclp_pkg::CHAR_D) &&
                       (head_reg[1] == tdclp_pkg::CHAR_COMMA);

    // shared decimal accumulator: base*10 + digit, capped at 2^31
    always_comb
    begin
        case (phase_reg)
            PH_DIG1: acc_base = first_reg;
            PH_DIG2: acc_base = second_reg;
            default: acc_base = '0;
        endcase
        acc_wide = {acc_base, 3'b000} + {2'b00, acc_base, 1'b0} + {31'd0, c[3:0]};
        acc_val  = (acc_wide > {3'b000, tdclp_pkg::MAG_CAP}) ? tdclp_pkg::MAG_CAP
                                                             : acc_wide[31:0];
    end

    always_comb
    begin
        line_len_next  = line_len_reg;
        text_len_next  = text_len_reg;
        head_next      = head_reg;
        zero_seen_next = zero_seen_reg;
        phase_next     = phase_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        neg_next       = neg_reg;

        if (in_acc && is_eol && (line_len_reg != '0))
        begin
            line_len_next  = '0;
            text_len_next  = '0;
            head_next      = '{default: 8'd0};
            zero_seen_next = 1'b0;
            phase_next     = PH_WS1;
            first_next     = '0;
            second_next    = '0;
            neg_next       = '0;
        end
        else if (store)
        begin
            line_len_next = line_len_reg + 1'b1;
            if (!zero_seen_reg && (c == 8'd0))
                zero_seen_next = 1'b1;
            if (is_text)
            begin
                if (text_len_reg < 3'd4)
                    head_next[text_len_reg[1:0]] = c;
                if (text_len_reg < 3'd5)
                    text_len_next = text_len_reg + 3'd1;
                if (is_d_line)
                begin
                    case (phase_reg)
                        PH_WS1, PH_WS2:
                        begin
                            if (c_ws)
                                phase_next = phase_reg;
                            else if (c_sign)
                            begin
                                if (c == tdclp_pkg::CHAR_MINUS)
                                begin
                                    if (phase_reg == PH_WS2)
                                        neg_next[1] = 1'b1;
                                    else
                                        neg_next[0] = 1'b1;
                                end
                                phase_next = (phase_reg == PH_WS2) ? PH_SIGN2 : PH_SIGN1;
                            end
                            else if (c_digit)
                            begin
                                if (phase_reg == PH_WS2)
                                begin
                                    second_next = acc_val;
                                    phase_next  = PH_DIG2;
                                end
                                else
                                begin
                                    first_next = acc_val;
                                    phase_next = PH_DIG1;
                                end
                            end
                            else
                                phase_next = PH_FAIL;
                        end
                        PH_SIGN1:
                        begin
                            if (c_digit)
                            begin
                                first_next = acc_val;
                                phase_next = PH_DIG1;
                            end
                            else
                                phase_next = PH_FAIL;
                        end
                        PH_SIGN2:
                        begin
                            if (c_digit)
                            begin
                                second_next = acc_val;
                                phase_next  = PH_DIG2;
                            end
                            else
                                phase_next = PH_FAIL;
                        end
                        PH_DIG1:
                        begin
                            if (c_digit)
                                first_next = acc_val;
                            else if (c == tdclp_pkg::CHAR_COMMA)
                                phase_next = PH_WS2;
                            else
                                phase_next = PH_FAIL;
                        end
                        PH_DIG2:
                        begin
                            if (c_digit)
                                second_next = acc_val;
                            else
                                phase_next = PH_DONE;
                        end
                        default:
                            phase_next = phase_reg;
                    endcase
                end
            end
        end
    end

    // result of the line that ends with this byte
    always_comb
    begin
        res = '0;
        if (is_d_line)
        begin
            if ((phase_reg == PH_DIG2) || (phase_reg == PH_DONE))
            begin
                res.drive_valid = 1'b1;
                if (neg_reg[0])
                    res.forward = 32'd0 - first_reg;
                else
                    res.forward = (first_reg >= tdclp_pkg::MAG_CAP) ? tdclp_pkg::POS_MAX
                                                                    : first_reg;
                if (neg_reg[1])
                    res.steer = 32'd0 - second_reg;
                else
                    res.steer = (second_reg >= tdclp_pkg::MAG_CAP) ? tdclp_pkg::POS_MAX
                                                                   : second_reg;
            end
        end
        else if (text_len_reg >= 3'd1)
        begin
            case (head_reg[0])
                tdclp_pkg::CHAR_F:
                begin
                    res.drive_valid = 1'b1;
                    res.forward     = {16'd0, full_speed_reg};
                end
                tdclp_pkg::CHAR_B:
                begin
                    res.drive_valid = 1'b1;
                    res.forward     = 32'd0 - {16'd0, full_speed_reg};
                end
                tdclp_pkg::CHAR_L:
                begin
                    res.drive_valid = 1'b1;
                    res.steer       = 32'd0 - {16'd0, turn_speed_reg};
                end
                tdclp_pkg::CHAR_R:
                begin
                    res.drive_valid = 1'b1;
                    res.steer       = {16'd0, turn_speed_reg};
                end
                tdclp_pkg::CHAR_S:
                    res.drive_valid = 1'b1;
                default:
                    res.drive_valid = 1'b0;
            endcase
            if ((text_len_reg >= 3'd3) && (head_reg[0] == tdclp_pkg::CHAR_L) &&
                (head_reg[1] == tdclp_pkg::CHAR_O) && (head_reg[2] == tdclp_pkg::CHAR_C))
            begin
                res.loc_request    = 1'b1;
                res.loc_has_number = (text_len_reg == 3'd5) &&
                                     (head_reg[3] == tdclp_pkg::CHAR_COMMA);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_speed_reg <= tdclp_pkg::FULL_SPEED_RST;
            turn_speed_reg <= tdclp_pkg::TURN_SPEED_RST;
            line_len_reg   <= '0;
            text_len_reg   <= '0;
            head_reg       <= '{default: 8'd0};
            zero_seen_reg  <= 1'b0;
            phase_reg      <= PH_WS1;
            first_reg      <= '0;
            second_reg     <= '0;
            neg_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2] == tdclp_pkg::REG_TURN_SPEED)
                    turn_speed_reg <= pwdata[15:0];
                else
                    full_speed_reg <= pwdata[15:0];
            end
            line_len_reg  <= line_len_next;
            text_len_reg  <= text_len_next;
            head_reg      <= head_next;
            zero_seen_reg <= zero_seen_next;
            phase_reg     <= phase_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            neg_reg       <= neg_next;

            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (!out_valid_reg || pop)
                begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tdclp_pkg::TDATA_W - tdclp_pkg::RESULT_W){1'b0}}, out_reg};

endmodule

FILE: design/tdclp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdclp_checker
// Port-level checks for the text drive command line parser.
// ----------------------------------------------------------------------------
module tdclp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        pready
);

    // stalled beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // no drive command means zero drive values
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[64:1] == 64'd0))
        else $error("drive values set without drive_valid");

    // number flag only with a location request
    a_loc_num: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[66] |-> m_tdata[65])
        else $error("loc_has_number without loc_request");

    // pad bits stay clear
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[71:67] == 5'd0))
        else $error("tdata pad bits set");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind text_drive_command_line_parser tdclp_checker u_tdclp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
